### sv/vvs_pkg.sv
package vvs_pkg;

	localparam int SIDE_DEF      = 16;
	localparam int ID_BITS_DEF   = 16;
	localparam int LOG_DEPTH_DEF = 64;

	localparam int OP_W    = 2;
	localparam int COORD_W = 8;
	localparam int BLK_W   = 16;
	localparam int VER_W   = 48;
	localparam int CAP_W   = 7;
	localparam int ST_W    = 3;

	localparam int MAX_RES = 64;
	localparam logic [VER_W-1:0] VER_MAX     = {VER_W{1'b1}};
	localparam logic [CAP_W-1:0] LIMIT_RESET = CAP_W'(64);

	typedef enum logic [OP_W-1:0] {
		OP_READ = 2'd0,
		OP_EDIT = 2'd1,
		OP_DIFF = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_READ   = 3'd0,
		ST_EDIT   = 3'd1,
		ST_ENTRY  = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_RESYNC = 3'd4
	} status_t;

endpackage

### sv/vvs_if.sv
interface vvs_req_if;
	logic                        valid;
	logic                        ready;
	logic [vvs_pkg::OP_W-1:0]    op;
	logic [vvs_pkg::COORD_W-1:0] pos_x;
	logic [vvs_pkg::COORD_W-1:0] pos_y;
	logic [vvs_pkg::COORD_W-1:0] pos_z;
	logic [vvs_pkg::BLK_W-1:0]   new_block;
	logic [vvs_pkg::VER_W-1:0]   known_version;
	logic [vvs_pkg::CAP_W-1:0]   max_entries;

	modport source (output valid, op, pos_x, pos_y, pos_z, new_block, known_version,
		max_entries, input ready);
	modport sink (input valid, op, pos_x, pos_y, pos_z, new_block, known_version,
		max_entries, output ready);
endinterface

interface vvs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [vvs_pkg::ST_W-1:0]    status;
	logic [vvs_pkg::COORD_W-1:0] out_x;
	logic [vvs_pkg::COORD_W-1:0] out_y;
	logic [vvs_pkg::COORD_W-1:0] out_z;
	logic [vvs_pkg::BLK_W-1:0]   block_value;
	logic [vvs_pkg::VER_W-1:0]   version_out;
	logic                        last;
	logic                        all_air;
	logic                        dirty_flag;

	modport source (output valid, status, out_x, out_y, out_z, block_value, version_out,
		last, all_air, dirty_flag, input ready);
	modport sink (input valid, status, out_x, out_y, out_z, block_value, version_out,
		last, all_air, dirty_flag, output ready);
endinterface

interface vvs_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [vvs_pkg::CAP_W-1:0] log_limit;

	modport source (output valid, log_limit, input ready);
	modport sink (input valid, log_limit, output ready);
endinterface

### sv/vvs_ram.sv
module vvs_ram #(
	parameter int DEPTH = vvs_pkg::LOG_DEPTH_DEF,
	parameter int WIDTH = vvs_pkg::BLK_W
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/versioned_voxel_store_with_edit_log.sv
// Voxel store of SIDE^3 block ids with a 48-bit saturating version and a ring log of
// real edits. After reset the block sweeps every cell of the store to air and takes no
// item until that is done; configuration beats are always taken. One item is worked at
// a time through a small sequencer around a simple dual-port store memory and a
// simple dual-port log memory (one write port, one read port each): a read goes from a
// store read to its result, an edit from a store read to the write and log append and
// then its result, and a diff query walks the log with one log read and one compare per
// entry, plus an empty answer when nothing matches; any stall on the result side holds
// it. Results, with the all-air and dirty flags, leave through an output register.
module versioned_voxel_store_with_edit_log #(
	parameter int SIDE      = vvs_pkg::SIDE_DEF,
	parameter int ID_BITS   = vvs_pkg::ID_BITS_DEF,
	parameter int LOG_DEPTH = vvs_pkg::LOG_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vvs_req_if.sink    req,
	vvs_rsp_if.source  rsp,
	vvs_cfg_if.sink    cfg
);

	localparam int CB    = $clog2(SIDE);
	localparam int CELLS = SIDE * SIDE * SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(CELLS + 1);
	localparam int SW    = ID_BITS < vvs_pkg::BLK_W ? ID_BITS : vvs_pkg::BLK_W;
	localparam int HW    = LOG_DEPTH > 1 ? $clog2(LOG_DEPTH) : 1;
	localparam int CW    = $clog2(LOG_DEPTH + 1);
	localparam int CWD   = vvs_pkg::COORD_W;
	localparam int VW    = vvs_pkg::VER_W;
	localparam int LEW   = 3 * CWD + SW + VW;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_VRD, S_VEX, S_EOUT, S_DRD, S_DEX, S_DEMP
	} state_t;

	state_t state_q;
	vvs_pkg::op_t op_q;
	logic [CWD-1:0] x_q, y_q, z_q;
	logic [SW-1:0] blk_q;
	logic [VW-1:0] known_q;
	logic [vvs_pkg::CAP_W-1:0] cap_q, n_q, limit_q;
	logic inb_q;
	logic [AW-1:0] cell_q, clr_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] ver_q;
	logic dirty_q;
	logic [HW-1:0] head_q, ptr_q;
	logic [CW-1:0] lcnt_q, idx_q;

	logic ov_q, olast_q, oair_q, odirty_q;
	logic [vvs_pkg::ST_W-1:0] ost_q;
	logic [CWD-1:0] ox_q, oy_q, oz_q;
	logic [vvs_pkg::BLK_W-1:0] oblk_q;
	logic [VW-1:0] over_q;

	// voxel store
	logic vwe, vre;
	logic [AW-1:0] vwaddr;
	logic [SW-1:0] vwdata, vrd;

	// edit log
	logic lwe, lre;
	logic [HW-1:0] lwaddr;
	logic [LEW-1:0] lwdata, lrd;

	logic in_acc, out_free, change, inb_in, drop, last_c;
	logic resync_c, entry_c, out_load;
	logic [AW-1:0] cell_in;
	logic [VW-1:0] new_ver, l_ver;
	logic [CW:0] pos_sum;
	logic [HW-1:0] pos;
	logic [vvs_pkg::CAP_W-1:0] cap_in;
	int lim_eff;

	assign in_acc   = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	assign inb_in = (32'(req.pos_x) < SIDE) && (32'(req.pos_y) < SIDE) &&
		(32'(req.pos_z) < SIDE);
	assign cell_in = AW'(32'(req.pos_x[CB-1:0]) +
		SIDE * (32'(req.pos_y[CB-1:0]) + SIDE * 32'(req.pos_z[CB-1:0])));
	assign cap_in = (req.max_entries == '0) ? vvs_pkg::CAP_W'(1) :
		(32'(req.max_entries) > vvs_pkg::MAX_RES) ? vvs_pkg::CAP_W'(vvs_pkg::MAX_RES) :
		req.max_entries;

	assign change  = (op_q == vvs_pkg::OP_EDIT) && inb_q && (vrd != blk_q);
	assign new_ver = (ver_q == vvs_pkg::VER_MAX) ? ver_q : ver_q + VW'(1);
	assign pos_sum = (CW + 1)'(head_q) + (CW + 1)'(lcnt_q);
	assign pos = (pos_sum >= (CW + 1)'(LOG_DEPTH)) ? HW'(pos_sum - (CW + 1)'(LOG_DEPTH)) :
		HW'(pos_sum);
	assign lim_eff = (32'(limit_q) > LOG_DEPTH) ? LOG_DEPTH : 32'(limit_q);
	assign drop = (32'(lcnt_q) + 1) > lim_eff;

	assign vwe    = (state_q == S_CLR) || ((state_q == S_VEX) && change);
	assign vwaddr = (state_q == S_CLR) ? clr_q : cell_q;
	assign vwdata = (state_q == S_CLR) ? '0 : blk_q;
	assign vre    = (state_q == S_VRD);

	assign lwe    = (state_q == S_VEX) && change;
	assign lwaddr = pos;
	assign lwdata = {z_q, y_q, x_q, blk_q, new_ver};
	assign lre    = (state_q == S_DRD);
	assign l_ver  = lrd[VW-1:0];
	assign last_c = (idx_q == lcnt_q - CW'(1)) || (n_q + vvs_pkg::CAP_W'(1) == cap_q);

	// head entry newer than the client's version: client missed dropped edits
	assign resync_c = (idx_q == '0) && (known_q < l_ver);
	assign entry_c  = (l_ver > known_q);
	assign out_load = out_free && (((state_q == S_VEX) && (op_q == vvs_pkg::OP_READ)) ||
		(state_q == S_EOUT) || (state_q == S_DEMP) ||
		((state_q == S_DEX) && (resync_c || entry_c)));

	vvs_ram #(.DEPTH(CELLS), .WIDTH(SW)) u_store (
		.clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
		.re(vre), .raddr(cell_q), .rdata(vrd)
	);

	vvs_ram #(.DEPTH(LOG_DEPTH), .WIDTH(LEW)) u_log (
		.clk(clk), .we(lwe), .waddr(lwaddr), .wdata(lwdata),
		.re(lre), .raddr(ptr_q), .rdata(lrd)
	);

	function automatic logic [HW-1:0] wrap_inc(input logic [HW-1:0] p);
		return (32'(p) == LOG_DEPTH - 1) ? '0 : p + HW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= '0;
			ver_q   <= '0;
			dirty_q <= 1'b0;
			head_q  <= '0;
			lcnt_q  <= '0;
			limit_q <= vvs_pkg::LIMIT_RESET;
			ov_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.log_limit;
			end
			// flags are taken with the beat so a later item cannot change them
			if (out_load) begin
				ov_q     <= 1'b1;
				oair_q   <= (cnt_q == '0);
				odirty_q <= dirty_q;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						op_q    <= vvs_pkg::op_t'(req.op);
						x_q     <= req.pos_x;
						y_q     <= req.pos_y;
						z_q     <= req.pos_z;
						blk_q   <= req.new_block[SW-1:0];
						known_q <= req.known_version;
						cap_q   <= cap_in;
						inb_q   <= inb_in;
						cell_q  <= cell_in;
						ptr_q   <= head_q;
						idx_q   <= '0;
						n_q     <= '0;
						priority case (vvs_pkg::op_t'(req.op))
							vvs_pkg::OP_READ, vvs_pkg::OP_EDIT: state_q <= S_VRD;
							vvs_pkg::OP_DIFF: state_q <= (lcnt_q == '0) ? S_DEMP : S_DRD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_VRD: state_q <= S_VEX;
				S_VEX: begin
					if (op_q == vvs_pkg::OP_READ) begin
						if (out_free) begin
							ost_q   <= vvs_pkg::ST_READ;
							ox_q    <= '0;
							oy_q    <= '0;
							oz_q    <= '0;
							oblk_q  <= inb_q ? vvs_pkg::BLK_W'(vrd) : '0;
							over_q  <= '0;
							olast_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						if (inb_q) begin
							ver_q   <= new_ver;
							dirty_q <= 1'b1;
						end
						if (change) begin
							if (vrd == '0) begin
								cnt_q <= cnt_q + NW'(1);
							end else if (blk_q == '0) begin
								cnt_q <= cnt_q - NW'(1);
							end
							if (drop) begin
								head_q <= wrap_inc(head_q);
							end else begin
								lcnt_q <= lcnt_q + CW'(1);
							end
						end
						state_q <= S_EOUT;
					end
				end
				S_EOUT: begin
					if (out_free) begin
						ost_q   <= vvs_pkg::ST_EDIT;
						ox_q    <= '0;
						oy_q    <= '0;
						oz_q    <= '0;
						oblk_q  <= '0;
						over_q  <= ver_q;
						olast_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DRD: state_q <= S_DEX;
				S_DEX: begin
					if (resync_c) begin
						if (out_free) begin
							ost_q   <= vvs_pkg::ST_RESYNC;
							ox_q    <= '0;
							oy_q    <= '0;
							oz_q    <= '0;
							oblk_q  <= '0;
							over_q  <= '0;
							olast_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (entry_c) begin
						if (out_free) begin
							ost_q   <= vvs_pkg::ST_ENTRY;
							oz_q    <= lrd[VW+SW+2*CWD+:CWD];
							oy_q    <= lrd[VW+SW+CWD+:CWD];
							ox_q    <= lrd[VW+SW+:CWD];
							oblk_q  <= vvs_pkg::BLK_W'(lrd[VW+:SW]);
							over_q  <= l_ver;
							olast_q <= last_c;
							if (last_c) begin
								state_q <= S_IDLE;
							end else begin
								n_q     <= n_q + vvs_pkg::CAP_W'(1);
								idx_q   <= idx_q + CW'(1);
								ptr_q   <= wrap_inc(ptr_q);
								state_q <= S_DRD;
							end
						end
					end else if (idx_q == lcnt_q - CW'(1)) begin
						state_q <= S_DEMP;
					end else begin
						idx_q   <= idx_q + CW'(1);
						ptr_q   <= wrap_inc(ptr_q);
						state_q <= S_DRD;
					end
				end
				S_DEMP: begin
					if (out_free) begin
						ost_q   <= vvs_pkg::ST_EMPTY;
						ox_q    <= '0;
						oy_q    <= '0;
						oz_q    <= '0;
						oblk_q  <= '0;
						over_q  <= '0;
						olast_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = ost_q;
	assign rsp.out_x       = ox_q;
	assign rsp.out_y       = oy_q;
	assign rsp.out_z       = oz_q;
	assign rsp.block_value = oblk_q;
	assign rsp.version_out = over_q;
	assign rsp.last        = olast_q;
	assign rsp.all_air     = oair_q;
	assign rsp.dirty_flag  = odirty_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= CELLS)
		else $error("non-air count above cell count");

	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(lcnt_q) <= LOG_DEPTH)
		else $error("log count above log depth");

	a_clean_version: assert property (@(posedge clk) disable iff (!arst_n)
		!dirty_q |-> (ver_q == '0))
		else $error("version moved without an applied edit");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !rsp.ready) |=> (ov_q && $stable(ost_q) && $stable(over_q)))
		else $error("result beat changed while stalled");

endmodule

### bench/vvs_voxel_scoreboard.sv
`timescale 1ns / 1ps
package vvs_voxel_tb_pkg;
	import vvs_pkg::*;

	typedef struct {
		logic [ST_W-1:0]    status;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [BLK_W-1:0]   blk;
		logic [VER_W-1:0]   ver;
		logic               last;
		logic               all_air;
		logic               dirty;
	} voxel_result_t;

	class voxel_scoreboard;
		logic [BLK_W-1:0]   cells[4096];
		int unsigned        solid_count;
		logic [VER_W-1:0]   version;
		bit                 dirty;
		logic [23:0]        hist_pos[64];
		logic [BLK_W-1:0]   hist_blk[64];
		logic [VER_W-1:0]   hist_ver[64];
		int unsigned        hist_head;
		int unsigned        hist_count;
		int unsigned        keep_limit;
		voxel_result_t      pending[$];
		int                 errors;
		int                 results_seen;

		function new();
			foreach (cells[i]) cells[i] = '0;
			solid_count = 0;
			version = '0;
			dirty = 0;
			hist_head = 0;
			hist_count = 0;
			keep_limit = 64;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_limit(logic [CAP_W-1:0] v);
			keep_limit = v;
		endfunction

		function void push(logic [ST_W-1:0] st, logic [7:0] x, logic [7:0] y, logic [7:0] z,
				logic [BLK_W-1:0] b, logic [VER_W-1:0] v, bit fin);
			voxel_result_t r;
			r.status = st; r.x = x; r.y = y; r.z = z; r.blk = b; r.ver = v; r.last = fin;
			r.all_air = (solid_count == 0);
			r.dirty = dirty;
			pending = {pending, r};
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [7:0] x, logic [7:0] y,
				logic [7:0] z, logic [BLK_W-1:0] nb, logic [VER_W-1:0] known,
				logic [CAP_W-1:0] cap_in);
			bit inb;
			int cell_idx;
			int unsigned cap, lim, p, n;
			logic [BLK_W-1:0] prev;
			inb = x < 16 && y < 16 && z < 16;
			cell_idx = x + 16 * (y + 16 * z);
			case (op)
				OP_READ: push(ST_READ, 0, 0, 0, inb ? cells[cell_idx] : '0, '0, 1);
				OP_EDIT: begin
					if (inb) begin
						prev = cells[cell_idx];
						if (version != VER_MAX) version++;
						dirty = 1;
						if (prev != nb) begin
							if (prev == 0) solid_count++;
							else if (nb == 0) solid_count--;
							cells[cell_idx] = nb;
							lim = keep_limit > 64 ? 64 : keep_limit;
							p = (hist_head + hist_count) % 64;
							hist_pos[p] = {z, y, x};
							hist_blk[p] = nb;
							hist_ver[p] = version;
							if (hist_count + 1 > lim) hist_head = (hist_head + 1) % 64;
							else hist_count++;
						end
					end
					push(ST_EDIT, 0, 0, 0, '0, version, 1);
				end
				OP_DIFF: begin
					cap = cap_in == 0 ? 1 : (cap_in > 64 ? 64 : cap_in);
					if (hist_count == 0) push(ST_EMPTY, 0, 0, 0, '0, '0, 1);
					else if (known < hist_ver[hist_head]) push(ST_RESYNC, 0, 0, 0, '0, '0, 1);
					else begin
						n = 0;
						for (int unsigned i = 0; i < hist_count && n < cap; i++) begin
							p = (hist_head + i) % 64;
							if (hist_ver[p] > known) begin
								push(ST_ENTRY, hist_pos[p][7:0], hist_pos[p][15:8],
									hist_pos[p][23:16], hist_blk[p], hist_ver[p], 0);
								n++;
							end
						end
						if (n == 0) push(ST_EMPTY, 0, 0, 0, '0, '0, 1);
						else pending[pending.size() - 1].last = 1;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(voxel_result_t got);
			voxel_result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				$error("unexpected result beat, status %0d", got.status);
				errors++;
				return;
			end
			want = pending[0];
			pending.delete(0);
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status); errors++;
			end
			if (got.x !== want.x) begin
				$error("out_x: expected %0d, got %0d", want.x, got.x); errors++;
			end
			if (got.y !== want.y) begin
				$error("out_y: expected %0d, got %0d", want.y, got.y); errors++;
			end
			if (got.z !== want.z) begin
				$error("out_z: expected %0d, got %0d", want.z, got.z); errors++;
			end
			if (got.blk !== want.blk) begin
				$error("block_value: expected %0h, got %0h", want.blk, got.blk); errors++;
			end
			if (got.ver !== want.ver) begin
				$error("version_out: expected %0h, got %0h", want.ver, got.ver); errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last); errors++;
			end
			if (got.all_air !== want.all_air) begin
				$error("all_air: expected %0d, got %0d", want.all_air, got.all_air); errors++;
			end
			if (got.dirty !== want.dirty) begin
				$error("dirty_flag: expected %0d, got %0d", want.dirty, got.dirty); errors++;
			end
		endfunction
	endclass
endpackage

### bench/versioned_voxel_store_with_edit_log_tb.sv
`timescale 1ns / 1ps
module versioned_voxel_store_with_edit_log_tb;
	import vvs_pkg::*;
	import vvs_voxel_tb_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;

	vvs_req_if req ();
	vvs_rsp_if rsp ();
	vvs_cfg_if cfg ();

	versioned_voxel_store_with_edit_log uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	always #10 clk = ~clk;

	voxel_scoreboard board;
	int  hold_cycles = 0;
	int  rsp_wait = 0;
	int  idle_count = 0;
	int  items_sent = 0;

	initial begin
		board = new();
		req.valid = 0; req.op = OP_READ; req.pos_x = 0; req.pos_y = 0; req.pos_z = 0;
		req.new_block = 0; req.known_version = 0; req.max_entries = 1;
		cfg.valid = 0; cfg.log_limit = LIMIT_RESET;
		rsp.ready = 0;
	end

	// valid stays up into a back-to-back item; drain() drops it
	task automatic send_item(op_t op, logic [7:0] x, logic [7:0] y, logic [7:0] z,
			logic [BLK_W-1:0] nb, logic [VER_W-1:0] kv, logic [CAP_W-1:0] cap);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1; req.op <= op; req.pos_x <= x; req.pos_y <= y; req.pos_z <= z;
		req.new_block <= nb; req.known_version <= kv; req.max_entries <= cap;
		do @(posedge clk); while (!req.ready);
		board.note_item(op, x, y, z, nb, kv, cap);
		items_sent++;
	endtask

	task automatic drain();
		req.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		// a trailing op 3 may still be in flight
		repeat (300) @(posedge clk);
	endtask

	task automatic write_limit(logic [CAP_W-1:0] v);
		drain();
		cfg.valid <= 1; cfg.log_limit <= v;
		do @(posedge clk); while (!cfg.ready);
		board.set_limit(v);
		cfg.valid <= 0;
	endtask

	task automatic send_random(int unsigned count);
		logic [7:0] x, y, z;
		logic [VER_W-1:0] kv;
		int unsigned sel;
		op_t op;
		repeat (count) begin
			sel = $urandom_range(0, 99);
			op = sel < 35 ? OP_EDIT : sel < 60 ? OP_READ : sel < 95 ? OP_DIFF : OP_NONE;
			if ($urandom_range(0, 9) == 0) begin
				x = 8'($urandom); y = 8'($urandom); z = 8'($urandom);
			end else begin
				x = 8'($urandom_range(0, 3)); y = 8'($urandom_range(0, 3));
				z = 8'($urandom_range(0, 15));
			end
			case ($urandom_range(0, 4))
				0: kv = VER_W'({$urandom, $urandom});
				1: kv = 0;
				default: kv = board.version > 40 ?
					board.version - VER_W'($urandom_range(0, 40)) :
					VER_W'($urandom_range(0, 40));
			endcase
			send_item(op, x, y, z, $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom),
				kv, 7'($urandom));
		end
	endtask

	// result side: a randomly drawn wait after each beat, plus a long hold-off on request
	always @(posedge clk) begin
		voxel_result_t r;
		int gap;
		if (rsp.valid && rsp.ready) begin
			r.status = rsp.status; r.x = rsp.out_x; r.y = rsp.out_y; r.z = rsp.out_z;
			r.blk = rsp.block_value; r.ver = rsp.version_out; r.last = rsp.last;
			r.all_air = rsp.all_air; r.dirty = rsp.dirty_flag;
			board.check_result(r);
		end
		if (!arst_n || hold_cycles > 0) begin
			rsp.ready <= 0;
		end else if (rsp.valid && rsp.ready) begin
			gap = $urandom_range(0, 6);
			rsp_wait <= gap;
			rsp.ready <= (gap == 0);
		end else if (rsp_wait > 0) begin
			rsp_wait <= rsp_wait - 1;
			rsp.ready <= (rsp_wait == 1);
		end else begin
			rsp.ready <= 1;
		end
		if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_count <= 0;
		else if (arst_n)
			idle_count <= idle_count + 1;
		if (idle_count > IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty log, bounds, air writes, changes, repeats
		send_item(OP_DIFF, 0, 0, 0, 0, 0, 0);
		send_item(OP_READ, 255, 255, 255, 0, 0, 1);
		send_item(OP_EDIT, 16, 0, 0, 16'hFFFF, 0, 1);
		send_item(OP_EDIT, 0, 0, 0, 0, 0, 1);
		send_item(OP_EDIT, 0, 0, 0, 16'hFFFF, 0, 1);
		send_item(OP_EDIT, 15, 15, 15, 16'h5A5A, 0, 1);
		send_item(OP_EDIT, 15, 15, 15, 16'h5A5A, 0, 1);
		send_item(OP_READ, 15, 15, 15, 0, 0, 1);
		send_item(OP_READ, 0, 0, 0, 0, 0, 1);
		send_item(OP_DIFF, 0, 0, 0, 0, 0, 0);
		send_item(OP_DIFF, 0, 0, 0, 0, {VER_W{1'b1}}, 7'h7F);
		send_item(OP_DIFF, 0, 0, 0, 0, 48'h1, 7'd64);
		send_item(OP_NONE, 1, 2, 3, 16'h1234, 48'hABC, 7'd5);
		send_item(OP_EDIT, 0, 0, 0, 0, 0, 1);
		send_item(OP_EDIT, 15, 15, 15, 0, 0, 1);
		send_item(OP_READ, 0, 15, 0, 0, 0, 1);
		send_item(OP_DIFF, 0, 0, 0, 0, 48'h0, 7'd64);

		// tiny limit forces resync answers
		write_limit(1);
		send_item(OP_EDIT, 1, 1, 1, 16'h0001, 0, 1);
		send_item(OP_EDIT, 2, 2, 2, 16'h0002, 0, 1);
		send_item(OP_DIFF, 0, 0, 0, 0, 0, 7'd10);
		send_item(OP_DIFF, 0, 0, 0, 0, board.version - 1, 7'd10);
		write_limit(0);
		send_item(OP_EDIT, 3, 3, 3, 16'h0003, 0, 1);
		send_item(OP_DIFF, 0, 0, 0, 0, 0, 7'd10);
		write_limit(7'h7F);
		send_random(50);

		// stall results long while items keep coming
		hold_cycles = 400;
		send_random(30);
		drain();

		write_limit(5);
		send_random(50);
		write_limit(64);
		send_random(60);

		drain();
		$display("Sent %0d items, checked %0d result beats across log limits 0..127.",
			items_sent, board.results_seen);
		$display("Covered reads, edits, no-op op codes, empty/resync/entry diffs.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### sim.f
sv/vvs_pkg.sv
sv/vvs_if.sv
sv/vvs_ram.sv
sv/versioned_voxel_store_with_edit_log.sv
bench/vvs_voxel_scoreboard.sv
bench/versioned_voxel_store_with_edit_log_tb.sv
